// ===== hw/rtl/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared symbol codes, character codes, result type and letter lookup for the
// Morse symbol decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int SYM_W   = 8;
    localparam int CHAR_W  = 7;
    localparam int COUNT_W = 3;
    localparam int PAT_W   = 5;

    localparam logic [SYM_W-1:0] SYM_DOT  = 8'd46;
    localparam logic [SYM_W-1:0] SYM_DASH = 8'd45;
    localparam logic [SYM_W-1:0] SYM_GAP  = 8'd32;
    localparam logic [SYM_W-1:0] SYM_WORD = 8'd47;

    localparam logic [CHAR_W-1:0] CH_UNKNOWN = 7'h3f;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 7'h20;

    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 3'd5;
    localparam logic [COUNT_W-1:0] OVER_COUNT  = 3'd6;

    typedef struct packed {
        logic [1:0]        num;
        logic [CHAR_W-1:0] char0;
        logic              last0;
        logic [CHAR_W-1:0] char1;
    } t_result_pair;

    function automatic logic [CHAR_W-1:0] lookup_letter(
        input logic [COUNT_W-1:0] len,
        input logic [PAT_W-1:0]   pat
    );
        logic [CHAR_W-1:0] ch;
        ch = CH_UNKNOWN;
        case ({len, pat})
            {3'd1, 5'b00000}: ch = 7'h45; // E
            {3'd1, 5'b00001}: ch = 7'h54; // T
            {3'd2, 5'b00000}: ch = 7'h49; // I
            {3'd2, 5'b00001}: ch = 7'h41; // A
            {3'd2, 5'b00010}: ch = 7'h4e; // N
            {3'd2, 5'b00011}: ch = 7'h4d; // M
            {3'd3, 5'b00000}: ch = 7'h53; // S
            {3'd3, 5'b00001}: ch = 7'h55; // U
            {3'd3, 5'b00010}: ch = 7'h52; // R
            {3'd3, 5'b00011}: ch = 7'h57; // W
            {3'd3, 5'b00100}: ch = 7'h44; // D
            {3'd3, 5'b00101}: ch = 7'h4b; // K
            {3'd3, 5'b00110}: ch = 7'h47; // G
            {3'd3, 5'b00111}: ch = 7'h4f; // O
            {3'd4, 5'b00000}: ch = 7'h48; // H
            {3'd4, 5'b00001}: ch = 7'h56; // V
            {3'd4, 5'b00010}: ch = 7'h46; // F
            {3'd4, 5'b00100}: ch = 7'h4c; // L
            {3'd4, 5'b00110}: ch = 7'h50; // P
            {3'd4, 5'b00111}: ch = 7'h4a; // J
            {3'd4, 5'b01000}: ch = 7'h42; // B
            {3'd4, 5'b01001}: ch = 7'h58; // X
            {3'd4, 5'b01010}: ch = 7'h43; // C
            {3'd4, 5'b01011}: ch = 7'h59; // Y
            {3'd4, 5'b01100}: ch = 7'h5a; // Z
            {3'd4, 5'b01101}: ch = 7'h51; // Q
            {3'd5, 5'b11111}: ch = 7'h30; // 0
            {3'd5, 5'b01111}: ch = 7'h31; // 1
            {3'd5, 5'b00111}: ch = 7'h32; // 2
            {3'd5, 5'b00011}: ch = 7'h33; // 3
            {3'd5, 5'b00001}: ch = 7'h34; // 4
            {3'd5, 5'b00000}: ch = 7'h35; // 5
            {3'd5, 5'b10000}: ch = 7'h36; // 6
            {3'd5, 5'b11000}: ch = 7'h37; // 7
            {3'd5, 5'b11100}: ch = 7'h38; // 8
            {3'd5, 5'b11110}: ch = 7'h39; // 9
            default:          ch = CH_UNKNOWN;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/morse_symbol_decoder.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_decoder
// Stored Morse symbol bytes in, ASCII text characters out.
//
// Input channel: i_valid / o_stall with i_symbol and i_end_of_message. A beat
// is taken on each edge with i_valid high and o_stall low. Dots and dashes
// build up a letter; a letter gap or word gap closes it, a word gap also
// yields a space, and a beat flagged end of message flushes a pending letter.
// Other bytes change nothing.
// Output channel: o_valid / i_stall with o_text_char and o_last_of_run, which
// marks the final character caused by one input beat.
// The first character of a beat is presented in the cycle after the beat is taken.
// Throughput: one input beat per cycle while i_stall is low; a word gap that closes
// a letter gives two characters and holds off input until the first has been taken,
// as the two-entry result register has a single output port.
// Reset: synchronous, active low; clears the pending letter and empties the
// result register.
// Stall: while i_stall is high the presented character holds; input is taken
// only while the result register will be empty at the next edge.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_symbol_decoder
    import msd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic               i_end_of_message,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CHAR_W-1:0]       o_text_char,
    output logic                    o_last_of_run
);

    t_result_pair results;
    logic         ready;
    logic         accept;

    assign o_stall = !ready;
    assign accept  = i_valid && ready;

    msd_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_symbol         (i_symbol),
        .i_end_of_message (i_end_of_message),
        .o_results        (results)
    );

    msd_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_results     (results),
        .o_ready       (ready),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_text_char   (o_text_char),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/msd_decode.sv =====
// ----------------------------------------------------------------------------
// msd_decode
// Letter accumulator: collects dots and dashes, closes letters on gaps and
// end of message, and forms the results of one input beat.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_decode
    import msd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [SYM_W-1:0]   i_symbol,
    input  wire logic               i_end_of_message,
    output t_result_pair            o_results
);

    logic [COUNT_W-1:0] r_count, n_count;
    logic [PAT_W-1:0]   r_pattern, n_pattern;

    logic               is_mark, is_dash, is_gap, is_word;
    logic [COUNT_W-1:0] mark_count;
    logic [PAT_W-1:0]   mark_pattern;
    logic               pend_after;
    logic               has_letter;
    logic [CHAR_W-1:0]  letter;

    always_comb begin
        is_dash = (i_symbol == SYM_DASH);
        is_mark = (i_symbol == SYM_DOT) || is_dash;
        is_gap  = (i_symbol == SYM_GAP);
        is_word = (i_symbol == SYM_WORD);

        if (r_count < MAX_SYMBOLS) begin
            mark_count   = r_count + 3'd1;
            mark_pattern = {r_pattern[PAT_W-2:0], is_dash};
        end else begin
            mark_count   = OVER_COUNT;
            mark_pattern = r_pattern;
        end

        if (is_mark) begin
            letter     = lookup_letter(mark_count, mark_pattern);
            pend_after = 1'b1;
        end else begin
            letter     = lookup_letter(r_count, r_pattern);
            pend_after = !(is_gap || is_word) && (r_count != '0);
        end

        has_letter = ((is_gap || is_word) && (r_count != '0))
                   || (i_end_of_message && pend_after);

        o_results.num   = {1'b0, has_letter} + {1'b0, is_word};
        o_results.char0 = has_letter ? letter : CH_SPACE;
        o_results.last0 = !(has_letter && is_word);
        o_results.char1 = CH_SPACE;

        n_count   = r_count;
        n_pattern = r_pattern;
        if (i_accept) begin
            if (is_mark && !i_end_of_message) begin
                n_count   = mark_count;
                n_pattern = mark_pattern;
            end else if (is_mark || is_gap || is_word || i_end_of_message) begin
                n_count   = '0;
                n_pattern = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_pattern <= '0;
        end else begin
            r_count   <= n_count;
            r_pattern <= n_pattern;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/msd_outbuf.sv =====
// ----------------------------------------------------------------------------
// msd_outbuf
// Two-entry result register: takes the results of one beat and presents them
// one per output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_outbuf
    import msd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_result_pair       i_results,
    output logic                    o_ready,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [CHAR_W-1:0]       o_text_char,
    output logic                    o_last_of_run
);

    logic [1:0]        r_fill, n_fill;
    logic [CHAR_W-1:0] r_char0, n_char0;
    logic              r_last0, n_last0;
    logic [CHAR_W-1:0] r_char1, n_char1;
    logic              pop;

    always_comb begin
        pop     = (r_fill != 2'd0) && !i_stall;
        o_ready = (r_fill == 2'd0) || ((r_fill == 2'd1) && !i_stall);
        o_valid = (r_fill != 2'd0);

        n_fill  = r_fill;
        n_char0 = r_char0;
        n_last0 = r_last0;
        n_char1 = r_char1;
        if (i_load && (i_results.num != 2'd0)) begin
            n_fill  = i_results.num;
            n_char0 = i_results.char0;
            n_last0 = i_results.last0;
            n_char1 = i_results.char1;
        end else if (pop) begin
            n_fill  = r_fill - 2'd1;
            n_char0 = r_char1;
            n_last0 = 1'b1;
        end
    end

    assign o_text_char   = r_char0;
    assign o_last_of_run = r_last0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char0 <= n_char0;
        r_last0 <= n_last0;
        r_char1 <= n_char1;
    end

endmodule

`default_nettype wire

// ===== verif/morse_symbol_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_decoder_checker
// Watches both channels of the Morse symbol decoder, works out the text each
// accepted symbol beat should give, and compares every accepted text beat
// field by field with the oldest outstanding character. Mismatches and
// unexpected text beats are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module morse_symbol_decoder_checker
    import msd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_sym_valid,
    input  logic              i_sym_stall,
    input  logic [SYM_W-1:0]  i_symbol,
    input  logic              i_end_of_message,
    input  logic              i_text_valid,
    input  logic              i_text_stall,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic              i_last_of_run,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              is_last;
    } t_text_beat;

    string morse_codes [36] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
        ".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
        "...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
        "-----", ".----", "..---", "...--", "....-", ".....", "-....",
        "--...", "---..", "----."
    };
    string glyph_order = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    t_text_beat         expected_text [$];
    t_text_beat         want;
    logic [COUNT_W-1:0] pend_len;
    logic [PAT_W-1:0]   pend_pat;
    int                 fails = 0;

    function automatic logic [CHAR_W-1:0] letter_for(
        input logic [COUNT_W-1:0] len,
        input logic [PAT_W-1:0]   pat
    );
        logic [CHAR_W-1:0] ch;
        logic [PAT_W-1:0]  code_pat;
        int                code_len;
        ch = CH_UNKNOWN;
        for (int i = 0; i < 36; i++) begin
            code_len = morse_codes[i].len();
            code_pat = '0;
            for (int k = 0; k < code_len; k++) begin
                code_pat = {code_pat[PAT_W-2:0], morse_codes[i].getc(k) == "-"};
            end
            if (code_len == int'(len) && code_pat == pat) begin
                ch = CHAR_W'(glyph_order.getc(i));
            end
        end
        return ch;
    endfunction

    function automatic void decode_symbol(input logic [SYM_W-1:0] sym, input logic eom);
        logic [CHAR_W-1:0] made [2];
        t_text_beat        beat;
        int                n;
        n = 0;
        if (sym == SYM_DOT || sym == SYM_DASH) begin
            if (pend_len < MAX_SYMBOLS) begin
                pend_pat = {pend_pat[PAT_W-2:0], sym == SYM_DASH};
                pend_len = pend_len + 3'd1;
            end else begin
                pend_len = OVER_COUNT;
            end
        end
        if ((sym == SYM_GAP || sym == SYM_WORD || eom) && pend_len != '0) begin
            made[n] = letter_for(pend_len, pend_pat);
            n++;
            pend_len = '0;
            pend_pat = '0;
        end
        if (sym == SYM_WORD) begin
            made[n] = CH_SPACE;
            n++;
        end
        for (int k = 0; k < n; k++) begin
            beat.ch = made[k];
            beat.is_last = (k == n - 1);
            expected_text.push_back(beat);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pend_len = '0;
            pend_pat = '0;
            expected_text.delete();
        end else begin
            if (i_text_valid && !i_text_stall) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected text beat: text_char %0d, last_of_run %0b",
                           i_text_char, i_last_of_run);
                    fails++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_text_char !== want.ch) begin
                        $error("text_char: expected %0d, got %0d", want.ch, i_text_char);
                        fails++;
                    end
                    if (i_last_of_run !== want.is_last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.is_last, i_last_of_run);
                        fails++;
                    end
                end
            end
            if (i_sym_valid && !i_sym_stall) begin
                decode_symbol(i_symbol, i_end_of_message);
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_text.size();
    end

endmodule

// ===== verif/morse_symbol_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// morse_symbol_decoder_tb
// Drives the Morse symbol decoder with a directed run of corner cases and
// then random messages of letters, overlong runs, gaps and junk bytes, with
// random idling on both channels and one long receiver hold-off. The checker
// beside the block reports mismatches; this top gives the verdict.
// ----------------------------------------------------------------------------
module morse_symbol_decoder_tb;
    import msd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_BEATS = 1550;
    localparam int CALM_BEATS  = 150;
    localparam int HOLD_CYCLES = 150;
    localparam int QUIET_LIMIT = 1000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sym_valid = 1'b0;
    logic [SYM_W-1:0]  sym_byte = '0;
    logic              sym_eom = 1'b0;
    logic              text_stall = 1'b0;
    logic              sym_stall;
    logic              text_valid;
    logic [CHAR_W-1:0] text_char;
    logic              text_last;
    int                fail_count;
    int                pending;

    int                counted = 0;
    int                gap_pct = 10;
    int                quiet_cycles = 0;
    bit                calm = 1'b0;
    bit                hold_armed = 1'b0;
    bit                hold_done = 1'b0;

    morse_symbol_decoder i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (sym_valid),
        .o_stall          (sym_stall),
        .i_symbol         (sym_byte),
        .i_end_of_message (sym_eom),
        .o_valid          (text_valid),
        .i_stall          (text_stall),
        .o_text_char      (text_char),
        .o_last_of_run    (text_last)
    );

    morse_symbol_decoder_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_sym_valid      (sym_valid),
        .i_sym_stall      (sym_stall),
        .i_symbol         (sym_byte),
        .i_end_of_message (sym_eom),
        .i_text_valid     (text_valid),
        .i_text_stall     (text_stall),
        .i_text_char      (text_char),
        .i_last_of_run    (text_last),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((sym_valid && !sym_stall) || (text_valid && !text_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic [SYM_W-1:0] sym, input logic eom);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            sym_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        sym_valid <= 1'b1;
        sym_byte <= sym;
        sym_eom <= eom;
        do @(posedge clk); while (sym_stall);
        if (eom || sym == SYM_DOT || sym == SYM_DASH || sym == SYM_GAP || sym == SYM_WORD) begin
            counted++;
        end
    endtask

    task automatic send_random(input logic [SYM_W-1:0] sym);
        send_beat(sym, $urandom_range(0, 24) == 0);
    endtask

    task automatic send_run(input int len, input logic [7:0] dashes);
        for (int k = len - 1; k >= 0; k--) begin
            send_random(dashes[k] ? SYM_DASH : SYM_DOT);
        end
    endtask

    // receiver: random stall bursts in stretches, one long hold-off
    initial begin
        bit quiet_stretch;
        wait (rst_n);
        forever begin
            quiet_stretch = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(20, 80)) begin
                if (hold_armed && !hold_done) begin
                    text_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    text_stall <= 1'b0;
                    hold_done = 1'b1;
                end else if (!calm && !quiet_stretch && $urandom_range(0, 4) == 0) begin
                    text_stall <= 1'b1;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                    text_stall <= 1'b0;
                end
                @(posedge clk);
            end
        end
    end

    initial begin
        int pick;
        int sep;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dot, dash, letter gap: A
        send_beat(SYM_DOT, 1'b0);
        send_beat(SYM_DASH, 1'b0);
        send_beat(SYM_GAP, 1'b0);
        // five dashes closed by a word gap: digit then space
        repeat (5) send_beat(SYM_DASH, 1'b0);
        send_beat(SYM_WORD, 1'b0);
        // gaps with nothing pending
        send_beat(SYM_WORD, 1'b0);
        send_beat(SYM_GAP, 1'b0);
        // overlong letter
        repeat (6) send_beat(SYM_DOT, 1'b0);
        send_beat(SYM_GAP, 1'b0);
        // ignored bytes, end of message flagged on an ignored byte
        send_beat(8'h00, 1'b0);
        send_beat(SYM_DOT, 1'b0);
        send_beat(8'hff, 1'b1);
        // end of message on a dash, then on a word gap closing a letter
        send_beat(SYM_DASH, 1'b1);
        send_beat(SYM_DOT, 1'b0);
        send_beat(SYM_DOT, 1'b0);
        send_beat(SYM_WORD, 1'b1);

        hold_armed = 1'b1;
        while (counted < TOTAL_BEATS) begin
            calm = (counted > TOTAL_BEATS - CALM_BEATS);
            if ($urandom_range(0, 29) == 0) begin
                pick = $urandom_range(0, 2);
                gap_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 35;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_run($urandom_range(1, 5), 8'($urandom));
            end else if (pick < 80) begin
                send_run($urandom_range(6, 8), 8'($urandom));
            end else if (pick < 90) begin
                send_random(SYM_W'($urandom_range(0, 255)));
            end
            sep = $urandom_range(0, 99);
            if (sep < 60) begin
                send_random(SYM_GAP);
            end else if (sep < 85) begin
                send_random(SYM_WORD);
            end else if (sep < 92) begin
                send_random(SYM_W'($urandom_range(0, 255)));
            end
        end

        sym_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
